// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ===== sv/setc_pkg.sv =====
// Package for the scope edge trigger capture block: widths, codes and defaults.
`default_nettype none
package setc_pkg;
   localparam int SAMPLE_FIELD_BITS   = 12;
   localparam int INDEX_FIELD_BITS    = 8;
   localparam int VALUE_FIELD_BITS    = 12;
   localparam int LEVEL_BITS          = 12;
   localparam int CSR_INDEX_BITS      = 2;
   localparam int CSR_DATA_BITS       = 12;

   localparam int RING_DEPTH_DEFAULT  = 256;
   localparam int SAMPLE_BITS_DEFAULT = 12;

   // lags behind the write position, taken after the position advances
   localparam int PREV_LAG = 32;
   localparam int CURR_LAG = 31;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_LEVEL  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDGE_SELECT    = 2'd2;

   localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 12'd2048;

   localparam logic EDGE_RISING  = 1'b0;
   localparam logic EDGE_FALLING = 1'b1;
endpackage
`default_nettype wire

// ===== sv/setc_ifs.sv =====
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface setc_req_if
   import setc_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [SAMPLE_FIELD_BITS-1:0] sample;
   logic [INDEX_FIELD_BITS-1:0]  read_index;

   modport source (output valid, op, sample, read_index, input ready);
   modport sink   (input valid, op, sample, read_index, output ready);
endinterface

interface setc_rsp_if
   import setc_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic                        trigger_hit;
   logic                        found;
   logic [VALUE_FIELD_BITS-1:0] read_value;

   modport source (output valid, trigger_hit, found, read_value, input ready);
   modport sink   (input valid, trigger_hit, found, read_value, output ready);
endinterface
`default_nettype wire

// ===== sv/scope_edge_trigger_capture_top.sv =====
// A response is registered and presented in the cycle after its request transaction.
// Requests are taken one transaction per cycle while the response side is ready,
// except a push that fires the trigger, after which requests stall while the cell
// chain rotates once past the copy tap, writing one capture entry per cycle.
// Reset: synchronous, clears cells, write side, found flag, config and response
// valid; capture store reads as zero until the first trigger: no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module scope_edge_trigger_capture_top
   import setc_pkg::*;
#(
   parameter int RING_DEPTH  = RING_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   setc_req_if.sink                       req_if,
   setc_rsp_if.source                     rsp_if,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);
   localparam int PTR_BITS = $clog2(RING_DEPTH);
   localparam int CMP_BITS = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
   // cell k holds the sample k+1 places behind the write position
   localparam int PREV_TAP = PREV_LAG - 2;  // read before the shift
   localparam int CUR_TAP  = CURR_LAG - 2;
   localparam int COPY_TAP = CURR_LAG - 1 + RING_DEPTH / 2;
   localparam logic [PTR_BITS-1:0] COPY_LAST = PTR_BITS'(RING_DEPTH - 1);

   // configuration
   logic [LEVEL_BITS-1:0] level_ff;
   logic                  enable_ff;
   logic                  edge_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= LEVEL_RESET;
         enable_ff   <= 1'b0;
         edge_sel_ff <= EDGE_RISING;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TRIGGER_LEVEL:  level_ff    <= csr_write_data[LEVEL_BITS-1:0];
            CSR_TRIGGER_ENABLE: enable_ff   <= csr_write_data[0];
            CSR_EDGE_SELECT:    edge_sel_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // control
   logic                copy_active_ff, copy_active_in;
   logic [PTR_BITS-1:0] copy_cnt_ff, copy_cnt_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic                rsp_found_ff;
   logic                rsp_read_ff;

   logic req_accept;
   logic push_accept;
   logic read_accept;
   logic hit;

   assign req_if.ready = !copy_active_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;
   assign push_accept  = req_accept && (req_if.op == OP_PUSH);
   assign read_accept  = req_accept && (req_if.op == OP_READ);

   // cell chain
   logic [SAMPLE_BITS-1:0] cell_q [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] chain_head;
   logic [CMP_BITS-1:0]    sample_wide;
   logic                   chain_advance;

   assign sample_wide   = CMP_BITS'(req_if.sample);
   // during a copy the chain closes into a loop and rotates once
   assign chain_head    = copy_active_ff ? cell_q[RING_DEPTH-1] : sample_wide[SAMPLE_BITS-1:0];
   assign chain_advance = push_accept || copy_active_ff;

   for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         setc_cell #(.DATA_BITS(SAMPLE_BITS)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (chain_advance),
            .data_in (chain_head),
            .data_q  (cell_q[k])
         );
      end else begin : g_body
         setc_cell #(.DATA_BITS(SAMPLE_BITS)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (chain_advance),
            .data_in (cell_q[k-1]),
            .data_q  (cell_q[k])
         );
      end
   end

   // edge detection on the delayed pair
   logic [CMP_BITS-1:0] prev_w, cur_w, level_w;
   logic                rising, falling;

   assign prev_w  = CMP_BITS'(cell_q[PREV_TAP]);
   assign cur_w   = CMP_BITS'(cell_q[CUR_TAP]);
   assign level_w = CMP_BITS'(level_ff);
   assign rising  = (prev_w < level_w) && (cur_w >= level_w);
   assign falling = (prev_w > level_w) && (cur_w <= level_w);
   assign hit     = push_accept && enable_ff && ((edge_sel_ff == EDGE_FALLING) ? falling : rising);

   // capture store
   logic [SAMPLE_BITS-1:0] mem_rd_data;
   logic                   read_in_range;

   assign read_in_range = ({1'b0, req_if.read_index} < (INDEX_FIELD_BITS + 1)'(RING_DEPTH));

   setc_capture_mem #(
      .DEPTH     (RING_DEPTH),
      .DATA_BITS (SAMPLE_BITS),
      .ADDR_BITS (PTR_BITS)
   ) u_capture_mem (
      .clock   (clock),
      .wr_en   (copy_active_ff),
      .wr_addr (copy_cnt_ff),
      .wr_data (cell_q[COPY_TAP]),
      .rd_en   (read_accept),
      .rd_addr (req_if.read_index[PTR_BITS-1:0]),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      copy_active_in = copy_active_ff;
      copy_cnt_in    = copy_cnt_ff;
      found_in       = found_ff || hit;
      rsp_valid_in   = rsp_valid_ff;
      if (copy_active_ff) begin
         copy_cnt_in = copy_cnt_ff + 1'b1;
         if (copy_cnt_ff == COPY_LAST) begin
            copy_active_in = 1'b0;
            copy_cnt_in    = '0;
         end
      end else if (hit) begin
         copy_active_in = 1'b1;
         copy_cnt_in    = '0;
      end
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         copy_active_ff <= 1'b0;
         copy_cnt_ff    <= '0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         copy_active_ff <= copy_active_in;
         copy_cnt_ff    <= copy_cnt_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_hit_ff   <= hit;
         rsp_found_ff <= found_in;
         // reads return zero until the first trigger fills the store
         rsp_read_ff  <= read_accept && read_in_range && found_ff;
      end
   end

   logic [CMP_BITS-1:0] rd_wide;
   assign rd_wide = CMP_BITS'(mem_rd_data);

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.trigger_hit = rsp_hit_ff;
   assign rsp_if.found       = rsp_found_ff;
   assign rsp_if.read_value  = rsp_read_ff ? rd_wide[VALUE_FIELD_BITS-1:0] : '0;

   `ASSERT_IMPLIES(a_no_accept_in_copy, clock, reset, copy_active_ff, !req_if.ready)
   `ASSERT_NEXT(a_found_sticky, clock, reset, found_ff, found_ff)
   `ASSERT_NEXT(a_hit_starts_copy, clock, reset, hit, copy_active_ff && (copy_cnt_ff == '0) && found_ff)
   `ASSERT_NEXT(a_copy_ends, clock, reset, copy_active_ff && (copy_cnt_ff == COPY_LAST), !copy_active_ff)
endmodule
`default_nettype wire

// ===== sv/setc_cell.sv =====
// One sample cell of the ring shift chain.
`default_nettype none
module setc_cell #(
   parameter int DATA_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [DATA_BITS-1:0] data_in,
   output logic      [DATA_BITS-1:0] data_q
);
   logic [DATA_BITS-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else if (advance) begin
         data_ff <= data_in;
      end
   end

   assign data_q = data_ff;
endmodule
`default_nettype wire

// ===== sv/setc_capture_mem.sv =====
// Capture store: single write port, one registered read port.
`default_nettype none
module setc_capture_mem #(
   parameter int DEPTH     = 256,
   parameter int DATA_BITS = 12,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);
   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire
